// ===== rtl/usbhid_pkg.sv =====
// Shared types, constants and a helper function for the boot mouse endpoint finder.
package usbhid_pkg;

  // Default cap on the descriptor set length that is parsed
  localparam int unsigned USBHID_MAX_LEN = 4096;

  // Descriptor type codes and field values
  localparam logic [7:0] DESC_CONFIG    = 8'd2;
  localparam logic [7:0] DESC_INTERFACE = 8'd4;
  localparam logic [7:0] DESC_ENDPOINT  = 8'd5;
  localparam logic [7:0] NO_INTERFACE   = 8'hFF;
  localparam logic [7:0] BOOT_SUBCLASS  = 8'd1;
  localparam logic [7:0] MOUSE_PROTOCOL = 8'd2;
  localparam logic [1:0] XFER_INTERRUPT = 2'd3;
  localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
  localparam logic [7:0] EP_MIN_LEN     = 8'd7;
  localparam logic [3:0] SPEED_HIGH_MIN = 4'd3;
  localparam logic [4:0] EXP_BASE       = 5'd3;
  localparam logic [4:0] EXP_CAP        = 5'd16;
  localparam logic [10:0] PKT_DEFAULT   = 11'd8;
  localparam logic [10:0] PKT_CAP       = 11'd64;
  localparam int unsigned OUT_DATA_W    = 64;

  // Output register state
  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;    // parse the accepted byte
    logic report;  // final byte accepted: load result, clear parse state
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic room;    // byte count still below the length cap
  } status_t;

  // ceil(log2(v)) for v >= 1, flat range compares
  function automatic logic [3:0] ceil_log2_8(input logic [7:0] v);
    logic [3:0] n;
    if (v > 8'd128) n = 4'd8;
    else if (v > 8'd64) n = 4'd7;
    else if (v > 8'd32) n = 4'd6;
    else if (v > 8'd16) n = 4'd5;
    else if (v > 8'd8) n = 4'd4;
    else if (v > 8'd4) n = 4'd3;
    else if (v > 8'd2) n = 4'd2;
    else if (v > 8'd1) n = 4'd1;
    else n = 4'd0;
    return n;
  endfunction

endpackage

// ===== rtl/usbhid_ctrl.sv =====
// Handshake controller: input acceptance and output register occupancy.
module usbhid_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tlast,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  usbhid_pkg::status_t status,
  output usbhid_pkg::cmd_t    cmd
);
  import usbhid_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // Next state and outputs
  always_comb begin
    state_next = state;
    m_tvalid   = 1'b0;
    s_tready   = 1'b1;
    case (state)
      ST_EMPTY: begin
        if (accept && s_tlast) state_next = ST_FULL;
      end
      ST_FULL: begin
        m_tvalid = 1'b1;
        s_tready = m_tready;
        if (m_tready && !(accept && s_tlast)) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  assign accept     = s_tvalid && s_tready;
  assign cmd.take   = accept && status.room;
  assign cmd.report = accept && s_tlast;

endmodule

// ===== rtl/usbhid_datapath.sv =====
// Descriptor walker, match registers and result formatting.
module usbhid_datapath #(
  parameter int unsigned MAX_LEN = usbhid_pkg::USBHID_MAX_LEN
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [7:0]                          data_byte,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [3:0]                          cfg_data,
  input  usbhid_pkg::cmd_t                    cmd,
  output usbhid_pkg::status_t                 status,
  output logic                                out_found,
  output logic [usbhid_pkg::OUT_DATA_W-1:0]   out_data
);
  import usbhid_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

  logic [3:0]       port_speed;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       desc_offset;
  logic [7:0]       desc_length;
  logic [7:0]       desc_kind;
  logic [7:0]       desc_bytes [6];
  logic [7:0]       open_interface;
  logic [7:0]       open_subclass;
  logic [7:0]       open_protocol;
  logic [7:0]       config_byte;
  logic             header_ok;
  logic             scan_stopped;
  logic             match_found;
  logic [7:0]       match_interface;
  logic [7:0]       match_endpoint;
  logic [10:0]      match_packet;
  logic [7:0]       match_interval;

  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]       desc_offset_next;
  logic [7:0]       desc_length_next;
  logic [7:0]       desc_kind_next;
  logic [7:0]       desc_bytes_next [6];
  logic [7:0]       open_interface_next;
  logic [7:0]       open_subclass_next;
  logic [7:0]       open_protocol_next;
  logic [7:0]       config_byte_next;
  logic             header_ok_next;
  logic             scan_stopped_next;
  logic             match_found_next;
  logic [7:0]       match_interface_next;
  logic [7:0]       match_endpoint_next;
  logic [10:0]      match_packet_next;
  logic [7:0]       match_interval_next;
  logic [7:0]       off_inc;
  logic [7:0]       byte_idx;

  // Result fields
  logic        res_found;
  logic [7:0]  iv;
  logic [4:0]  iexp;
  logic [10:0] pk;
  logic [4:0]  ctx;

  assign cfg_ready   = 1'b1;
  assign status.room = (byte_count < CNT_W'(MAX_LEN));

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      port_speed <= 4'd0;
    end else if (cfg_valid) begin
      port_speed <= cfg_data;
    end
  end

  // Per-byte walk over the descriptors
  always_comb begin
    byte_count_next      = byte_count;
    desc_offset_next     = desc_offset;
    desc_length_next     = desc_length;
    desc_kind_next       = desc_kind;
    desc_bytes_next      = desc_bytes;
    open_interface_next  = open_interface;
    open_subclass_next   = open_subclass;
    open_protocol_next   = open_protocol;
    config_byte_next     = config_byte;
    header_ok_next       = header_ok;
    scan_stopped_next    = scan_stopped;
    match_found_next     = match_found;
    match_interface_next = match_interface;
    match_endpoint_next  = match_endpoint;
    match_packet_next    = match_packet;
    match_interval_next  = match_interval;
    off_inc              = desc_offset + 8'd1;
    byte_idx             = desc_offset - 8'd2;

    if (cmd.take) begin
      byte_count_next = byte_count + CNT_W'(1);
      if (byte_count == CNT_W'(1)) header_ok_next = (data_byte == DESC_CONFIG);
      if (byte_count == CNT_W'(5)) config_byte_next = data_byte;
      if (!scan_stopped && !match_found) begin
        if (desc_offset == 8'd0) begin
          // length byte opens a descriptor
          desc_length_next = data_byte;
          if (data_byte < 8'd2) scan_stopped_next = 1'b1;
          else desc_offset_next = 8'd1;
        end else begin
          if (desc_offset == 8'd1) desc_kind_next = data_byte;
          else if (desc_offset < 8'd8) desc_bytes_next[byte_idx[2:0]] = data_byte;
          desc_offset_next = off_inc;
          // descriptor complete
          if (off_inc >= 8'd2 && off_inc == desc_length) begin
            desc_offset_next = 8'd0;
            if (desc_kind_next == DESC_INTERFACE && desc_length >= IFACE_MIN_LEN) begin
              open_interface_next = desc_bytes_next[0];
              open_subclass_next  = desc_bytes_next[4];
              open_protocol_next  = desc_bytes_next[5];
            end else if (desc_kind_next == DESC_ENDPOINT && desc_length >= EP_MIN_LEN &&
                         open_interface != NO_INTERFACE &&
                         open_subclass == BOOT_SUBCLASS &&
                         open_protocol == MOUSE_PROTOCOL) begin
              if (desc_bytes_next[0][7] && desc_bytes_next[1][1:0] == XFER_INTERRUPT) begin
                match_found_next     = 1'b1;
                match_interface_next = open_interface;
                match_endpoint_next  = desc_bytes_next[0];
                match_packet_next    = {desc_bytes_next[3][2:0], desc_bytes_next[2]};
                match_interval_next  = desc_bytes_next[4];
              end
            end
          end
        end
      end
    end
  end

  // Result from the state after the final byte
  always_comb begin
    res_found = match_found_next && header_ok_next && (byte_count_next >= CNT_W'(9));
    iv        = (match_interval_next == 8'd0) ? 8'd1 : match_interval_next;
    if (port_speed < SPEED_HIGH_MIN) begin
      iexp = EXP_BASE + {1'b0, ceil_log2_8(iv)};
    end else if (iv > {3'd0, EXP_CAP}) begin
      iexp = EXP_CAP;
    end else begin
      iexp = iv[4:0];
    end
    if (match_packet_next == 11'd0) pk = PKT_DEFAULT;
    else if (match_packet_next > PKT_CAP) pk = PKT_CAP;
    else pk = match_packet_next;
    ctx = {match_endpoint_next[3:0], 1'b1};
  end

  // Parse state registers, cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst || cmd.report) begin
      byte_count      <= '0;
      desc_offset     <= 8'd0;
      desc_length     <= 8'd0;
      desc_kind       <= 8'd0;
      for (int i = 0; i < 6; i++) desc_bytes[i] <= 8'd0;
      open_interface  <= NO_INTERFACE;
      open_subclass   <= 8'd0;
      open_protocol   <= 8'd0;
      config_byte     <= 8'd0;
      header_ok       <= 1'b0;
      scan_stopped    <= 1'b0;
      match_found     <= 1'b0;
      match_interface <= 8'd0;
      match_endpoint  <= 8'd0;
      match_packet    <= 11'd0;
      match_interval  <= 8'd0;
    end else begin
      byte_count      <= byte_count_next;
      desc_offset     <= desc_offset_next;
      desc_length     <= desc_length_next;
      desc_kind       <= desc_kind_next;
      desc_bytes      <= desc_bytes_next;
      open_interface  <= open_interface_next;
      open_subclass   <= open_subclass_next;
      open_protocol   <= open_protocol_next;
      config_byte     <= config_byte_next;
      header_ok       <= header_ok_next;
      scan_stopped    <= scan_stopped_next;
      match_found     <= match_found_next;
      match_interface <= match_interface_next;
      match_endpoint  <= match_endpoint_next;
      match_packet    <= match_packet_next;
      match_interval  <= match_interval_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_found <= 1'b0;
      out_data  <= '0;
    end else if (cmd.report) begin
      out_found <= res_found;
      if (res_found) begin
        out_data <= {4'd0, pk[6:0], iexp, ctx, config_byte_next, match_interval_next,
                     match_packet_next, match_endpoint_next, match_interface_next};
      end else begin
        out_data <= '0;
      end
    end
  end

endmodule

// ===== rtl/usb_hid_mouse_endpoint_finder_core.sv =====
// Top level of the boot mouse interrupt IN endpoint finder.
//
// Input stream: one descriptor byte per item on s_tdata, s_tlast on the
// final byte of a configuration descriptor set. Bytes past MAX_LEN are
// skipped, but a final flag on them still reports.
// Output stream: one item per descriptor set, issued after the final byte.
// m_tuser is the found flag; when it is low all of m_tdata is zero.
// Config channel: cfg_valid/cfg_data write port_speed; cfg_ready is always
// high. Write it only while no descriptor set is in flight.
//
// Throughput: one byte per cycle while s_tready is high. The walk and the
// final formatting are done in the cycle the byte is taken, so the result
// item appears in the cycle after the final byte is accepted. The single
// output register holds it; while it is full and m_tready is low, s_tready
// drops, otherwise the next set streams in right behind the result.
//
// Reset: rst (synchronous, active high) clears the parse state, port_speed
// and the output register. No clearing pass is needed.
module usb_hid_mouse_endpoint_finder_core #(
  parameter int unsigned MAX_LEN = usbhid_pkg::USBHID_MAX_LEN
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] data_byte
  input  logic                              s_tlast,   // last
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] interface_number, [15:8] endpoint_address, [26:16] max_packet,
  // [34:27] poll_interval, [42:35] config_value, [47:43] dev_ctx_idx,
  // [52:48] interval_exponent, [59:53] clamped_packet, [63:60] zero
  output logic [usbhid_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                              m_tuser,   // [0] found
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [3:0]                        cfg_data   // port_speed
);
  import usbhid_pkg::*;

  cmd_t    cmd;
  status_t status;

  usbhid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  usbhid_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .data_byte (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_found (m_tuser),
    .out_data  (m_tdata)
  );

endmodule
